// ===== hdl/dwlfo_pkg.sv =====
package dwlfo_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_DRAW   = 2'd1,
    CMD_SMOOTH = 2'd2,
    CMD_SINE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_INTERPOLATE = 2'd0,
    CFG_LEVEL       = 2'd1,
    CFG_OFFSET      = 2'd2
  } cfg_index_t;

  localparam int DIV_W = 16;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          Q15_MAX     = 32767;
  // 2^20 / 5 rounded up; exact floor(m / 5) for m below 2^18
  localparam logic [17:0] RECIP5      = 18'd209716;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_res_t;

endpackage

// ===== hdl/drawable_wavetable_lfo_top.sv =====
// Tick: phase read at accept, then table read, interpolation multiply, gain multiply, rounding
//   divide and clamp into the result register; the next tick is taken only after that write.
// Draw: the serial divider sizes the slope, then one point a cycle.
// Smooth: one pass over the table; restore sine: one point a cycle.
// Reset: rst synchronous, active high; a sine pass fills the table while in_stall is high.
//   Voice phases read as zero until first written.
module drawable_wavetable_lfo_top #(
  parameter int TABLE_POINTS = 1024,
  parameter int VOICE_COUNT  = 16
) (
  input  logic               clk,
  input  logic               rst,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [3:0]         voice,
  input  logic [31:0]        phase_step,
  input  logic [9:0]         from_index,
  input  logic signed [15:0] from_value,
  input  logic [9:0]         to_index,
  input  logic signed [15:0] to_value,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_value,
  output logic [3:0]         voice_out,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // TABLE_POINTS must be a power of two (the block does not enforce it): the phase top bits index the table directly
  localparam int AW = $clog2(TABLE_POINTS);
  localparam int FW = 32 - AW;
  localparam int PW = FW + 18;
  localparam int CW = AW + 1;
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int DW = dwlfo_pkg::DIV_W;

  typedef logic signed [15:0] sine_rom_t [TABLE_POINTS];

  // One sine cycle by quarter-wave symmetry and a Horner Taylor series in Q30
  function automatic sine_rom_t sine_rom_init();
    sine_rom_t   rom;
    logic [63:0] p, quad, r, x, x2, t, s, y;
    int          i;
    for (i = 0; i < TABLE_POINTS; i++) begin
      p    = (64'(i) << 32) / 64'(TABLE_POINTS);
      quad = p >> 30;
      r    = p & 64'h3FFF_FFFF;
      if (quad[0]) r = dwlfo_pkg::Q30_ONE - r;
      x  = (r * dwlfo_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = dwlfo_pkg::Q30_ONE - x2 / 64'd72;
      t  = dwlfo_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = dwlfo_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = dwlfo_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      y  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (y > 64'd32767) y = 64'd32767;
      rom[i] = (quad >= 64'd2) ? -16'(y) : 16'(y);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_init();

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SINE   = 9'b000000010,
    ST_SMOOTH = 9'b000000100,
    ST_DR_DIV = 9'b000001000,
    ST_DR_RUN = 9'b000010000,
    ST_T_RD   = 9'b000100000,
    ST_T_MUL  = 9'b001000000,
    ST_T_GAIN = 9'b010000000,
    ST_T_DIV  = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic               interpolate;
  logic [14:0]        level;
  logic signed [15:0] offset;

  // memories
  logic signed [15:0] shape_mem [TABLE_POINTS];
  logic [31:0]        phase_mem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] phase_ok;
  logic               tw_en;
  logic [AW-1:0]      tw_addr;
  logic signed [15:0] tw_data;
  logic [AW-1:0]      ra0, ra1;
  logic signed [15:0] rd0, rd1;
  logic [VW-1:0]      pa;
  logic [31:0]        pd;
  logic               pd_ok;

  logic accept;

  // tick path
  logic [3:0]            voice_q;
  logic [31:0]           step_q;
  logic [31:0]           ph;
  logic [FW-1:0]         fr_q;
  logic signed [16:0]    dlt;
  logic signed [PW-1:0]  prod_q;
  logic signed [PW-1:0]  rsum;
  logic signed [16:0]    v0_q;
  logic signed [16:0]    v_int;
  logic signed [32:0]    gp_q;
  logic [32:0]           g_abs;
  logic [31:0]           g_y;
  logic [17:0]           g_q0;
  logic [17:0]           g_r;
  logic [17:0]           g_q;
  logic signed [18:0]    g_s;
  logic signed [18:0]    g_sum;
  logic signed [15:0]    g_out;

  // sine pass
  logic [CW-1:0]      cnt;
  logic               rom_v;
  logic [AW-1:0]      rom_a;
  logic signed [15:0] sine_q;

  // smoothing pass: element stream, 5-point window, divide-by-5 pipeline
  logic [CW-1:0]      sm_c;
  logic               el_v, el_saved;
  logic [CW-1:0]      el_idx;
  logic signed [15:0] el_val;
  logic signed [15:0] save0, save1;
  logic signed [15:0] win [5];
  logic               w_v, a_v, b_v;
  logic [AW-1:0]      w_addr, a_addr, b_addr;
  logic               a_neg, b_neg;
  logic [17:0]        a_m;
  logic [35:0]        b_p;
  logic signed [18:0] sm_sum;
  logic [18:0]        sm_abs;
  logic [15:0]        sm_q;
  logic signed [15:0] sm_data;

  // segment draw
  logic [AW-1:0]      from_c, to_c;
  logic signed [15:0] fv_c, tv_c;
  logic signed [16:0] dd_c;
  logic [AW-1:0]      span_c;
  logic signed [15:0] fv_q;
  logic [AW-1:0]      dr_addr, dr_span, dr_i;
  logic               dr_up, dr_neg;
  logic [16:0]        dr_q;
  logic [AW:0]        dr_r;
  logic [DW-1:0]      dr_qd;
  logic [AW-1:0]      dr_rd;
  logic [AW:0]        dr_rsum;
  logic signed [15:0] dr_val;

  dwlfo_pkg::div_req_t div_req;
  dwlfo_pkg::div_res_t div_res;

  dwlfo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      interpolate <= 1'b1;
      level       <= 15'd32767;
      offset      <= '0;
    end else if (cfg_valid) begin
      unique case (dwlfo_pkg::cfg_index_t'(cfg_index))
        dwlfo_pkg::CFG_INTERPOLATE: interpolate <= cfg_data[0];
        dwlfo_pkg::CFG_LEVEL:       level       <= cfg_data[14:0];
        dwlfo_pkg::CFG_OFFSET:      offset      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (tw_en) shape_mem[tw_addr] <= tw_data;
    rd0    <= shape_mem[ra0];
    rd1    <= shape_mem[ra1];
    sine_q <= SINE_ROM[cnt[AW-1:0]];
    pd     <= phase_mem[pa];
    if (state == ST_T_RD) phase_mem[VW'(voice_q)] <= ph;
  end

  // valid bits make never-advanced voices read as phase zero
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ok <= '0;
      pd_ok    <= 1'b0;
    end else begin
      pd_ok <= phase_ok[pa];
      if (state == ST_T_RD) phase_ok[VW'(voice_q)] <= 1'b1;
    end
  end

  assign pa = VW'(voice);

  // ---------------------------------------------------------------- input decode
  always_comb begin
    from_c = (32'(from_index) > 32'(TABLE_POINTS - 1)) ? AW'(TABLE_POINTS - 1)
                                                       : AW'(from_index);
    to_c   = (32'(to_index) > 32'(TABLE_POINTS - 1)) ? AW'(TABLE_POINTS - 1)
                                                     : AW'(to_index);
    fv_c   = (from_value == 16'sh8000) ? -16'sd32767 : from_value;
    tv_c   = (to_value == 16'sh8000) ? -16'sd32767 : to_value;
    dd_c   = 17'(tv_c) - 17'(fv_c);
    span_c = (to_c > from_c) ? (to_c - from_c) : (from_c - to_c);
    div_req.start    = accept && (dwlfo_pkg::cmd_t'(cmd) == dwlfo_pkg::CMD_DRAW) &&
                       (from_c != to_c);
    div_req.dividend = DW'(dd_c[16] ? -dd_c : dd_c);
    div_req.divisor  = DW'(span_c);
  end

  // ---------------------------------------------------------------- tick datapath
  always_comb begin
    ph    = (pd_ok ? pd : 32'd0) + step_q;
    dlt   = interpolate ? (17'(rd1) - 17'(rd0)) : 17'sd0;
    rsum  = prod_q + $signed(PW'(1) << (FW - 1));
    v_int = v0_q + 17'(rsum >>> FW);
    // round(|g| / 32767): split at 2^15 and fix up with two compares
    g_abs = gp_q[32] ? 33'(-gp_q) : 33'(gp_q);
    g_y   = 32'(g_abs) + 32'd16383;
    g_q0  = 18'(g_y >> 15);
    g_r   = 18'(g_y[14:0]) + g_q0;
    g_q   = g_q0 + 18'(g_r >= 18'd32767) + 18'(g_r >= 18'd65534);
    g_s   = gp_q[32] ? -19'(g_q) : 19'(g_q);
    g_sum = g_s + 19'(offset);
    if (g_sum > 19'sd32767) g_out = 16'sd32767;
    else if (g_sum < -19'sd32767) g_out = -16'sd32767;
    else g_out = 16'(g_sum);
  end

  // ---------------------------------------------------------------- smoothing datapath
  always_comb begin
    el_val  = el_saved ? (el_idx[0] ? save1 : save0) : rd0;
    sm_sum  = 19'(win[0]) + 19'(win[1]) + 19'(win[2]) + 19'(win[3]) + 19'(win[4]);
    sm_abs  = sm_sum[18] ? 19'(-sm_sum) : 19'(sm_sum);
    sm_q    = 16'(b_p >> 20);
    sm_data = b_neg ? -$signed(sm_q) : $signed(sm_q);
  end

  // ---------------------------------------------------------------- draw datapath
  always_comb begin
    dr_rsum = dr_r + (AW + 1)'(dr_rd);
    dr_val  = 16'(18'(fv_q) + (dr_neg ? -18'(dr_q) : 18'(dr_q)));
  end

  // ---------------------------------------------------------------- table port mux
  always_comb begin
    tw_en   = 1'b0;
    tw_addr = '0;
    tw_data = '0;
    ra0     = '0;
    ra1     = '0;
    unique case (state)
      ST_SINE: begin
        tw_en   = rom_v;
        tw_addr = rom_a;
        tw_data = sine_q;
      end
      ST_SMOOTH: begin
        ra0     = AW'(sm_c - CW'(2));
        tw_en   = b_v;
        tw_addr = b_addr;
        tw_data = sm_data;
      end
      ST_DR_RUN: begin
        tw_en   = 1'b1;
        tw_addr = dr_addr;
        tw_data = dr_val;
      end
      ST_T_RD: begin
        ra0 = ph[31:FW];
        ra1 = ph[31:FW] + AW'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SINE;
      cnt       <= '0;
      rom_v     <= 1'b0;
      sm_c      <= '0;
      el_v      <= 1'b0;
      w_v       <= 1'b0;
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rom_v <= 1'b0;
      el_v  <= 1'b0;
      w_v   <= 1'b0;
      a_v   <= w_v;
      b_v   <= a_v;
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (dwlfo_pkg::cmd_t'(cmd))
              dwlfo_pkg::CMD_TICK: begin
                // drop ticks for voices beyond the phase store
                if (32'(voice) < 32'(VOICE_COUNT)) state <= ST_T_RD;
              end
              dwlfo_pkg::CMD_DRAW: begin
                state <= (from_c == to_c) ? ST_DR_RUN : ST_DR_DIV;
              end
              dwlfo_pkg::CMD_SMOOTH: begin
                sm_c  <= '0;
                state <= ST_SMOOTH;
              end
              dwlfo_pkg::CMD_SINE: begin
                cnt   <= '0;
                state <= ST_SINE;
              end
              default: ;
            endcase
          end
        end
        ST_SINE: begin
          rom_v <= 1'b1;
          cnt   <= cnt + CW'(1);
          if (cnt == CW'(TABLE_POINTS)) begin
            rom_v <= 1'b0;
            state <= ST_IDLE;
          end
        end
        ST_SMOOTH: begin
          if (sm_c <= CW'(TABLE_POINTS + 3)) begin
            el_v <= 1'b1;
            sm_c <= sm_c + CW'(1);
          end
          if (el_v) w_v <= (el_idx >= CW'(4));
          if (sm_c == CW'(TABLE_POINTS + 4) && !el_v && !w_v && !a_v && !b_v)
            state <= ST_IDLE;
        end
        ST_DR_DIV: begin
          if (div_res.done) state <= ST_DR_RUN;
        end
        ST_DR_RUN: begin
          if (dr_i == dr_span) state <= ST_IDLE;
        end
        ST_T_RD:   state <= ST_T_MUL;
        ST_T_MUL:  state <= ST_T_GAIN;
        ST_T_GAIN: state <= ST_T_DIV;
        ST_T_DIV: begin
          // hold until the result register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    rom_a <= cnt[AW-1:0];

    if (accept) begin
      voice_q <= voice;
      step_q  <= phase_step;
      fv_q    <= (from_c == to_c) ? tv_c : fv_c;
      dr_addr <= from_c;
      dr_span <= (from_c == to_c) ? '0 : span_c;
      dr_up   <= to_c > from_c;
      dr_neg  <= dd_c[16];
      dr_i    <= '0;
      dr_q    <= '0;
    end

    // tick stages
    if (state == ST_T_RD) fr_q <= ph[FW-1:0];
    if (state == ST_T_MUL) begin
      prod_q <= dlt * $signed({1'b0, fr_q});
      v0_q   <= 17'(rd0);
    end
    if (state == ST_T_GAIN) gp_q <= v_int * $signed({2'b00, level});
    if (state == ST_T_DIV && (!out_valid || !out_stall)) begin
      sample_value <= g_out;
      voice_out    <= voice_q;
    end

    // smoothing stream: keep the first two points before they are overwritten
    el_idx   <= sm_c;
    el_saved <= sm_c >= CW'(TABLE_POINTS + 2);
    if (el_v) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= win[4];
      win[4] <= el_val;
      w_addr <= AW'(el_idx - CW'(4));
      if (!el_saved && el_idx == CW'(2)) save0 <= rd0;
      if (!el_saved && el_idx == CW'(3)) save1 <= rd0;
    end
    a_m    <= 18'(sm_abs) + 18'd2;
    a_neg  <= sm_sum[18];
    a_addr <= w_addr;
    b_p    <= a_m * dwlfo_pkg::RECIP5;
    b_neg  <= a_neg;
    b_addr <= a_addr;

    // segment: whole and fractional slope, then advance one point a cycle
    if (state == ST_DR_DIV && div_res.done) begin
      dr_qd <= div_res.quotient;
      dr_rd <= AW'(div_res.remainder);
      dr_r  <= (AW + 1)'(dr_span >> 1);
    end
    if (state == ST_DR_RUN) begin
      dr_i    <= dr_i + AW'(1);
      dr_addr <= dr_up ? (dr_addr + AW'(1)) : (dr_addr - AW'(1));
      if (dr_rsum >= {1'b0, dr_span}) begin
        dr_r <= dr_rsum - {1'b0, dr_span};
        dr_q <= dr_q + 17'(dr_qd) + 17'd1;
      end else begin
        dr_r <= dr_rsum;
        dr_q <= dr_q + 17'(dr_qd);
      end
    end
  end

  // ---------------------------------------------------------------- assertions
  a_no_table_write_on_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_T_RD || state == ST_T_MUL || state == ST_T_GAIN || state == ST_T_DIV)
      |-> !tw_en)
    else $error("table written during a tick");

  a_div_done_in_draw: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DR_DIV)
    else $error("divider finished outside segment setup");

  a_tick_waits_for_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_T_DIV && out_valid && out_stall) |=> state == ST_T_DIV)
    else $error("tick result left while result register was full");

  a_sample_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_value != 16'sh8000)
    else $error("sample outside symmetric Q1.15 range");

endmodule

// ===== hdl/dwlfo_div.sv =====
module dwlfo_div (
  input  logic                clk,
  input  logic                rst,
  input  dwlfo_pkg::div_req_t req,
  output dwlfo_pkg::div_res_t res
);

  localparam int DW = dwlfo_pkg::DIV_W;
  localparam int NW = $clog2(DW + 1);

  logic          busy;
  logic          done;
  logic [NW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [DW:0]   trial;
  logic          fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, quo[DW-1]};
    fits  = trial >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= NW'(DW);
        rem  <= '0;
        quo  <= req.dividend;
        dv   <= req.divisor;
      end else if (busy) begin
        rem <= fits ? DW'(trial - {1'b0, dv}) : trial[DW-1:0];
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int POINTS = 1024;
  localparam int VOICES = 16;
  // longest edit pass (smooth or a full draw) plus margin
  localparam int EDIT_SETTLE = POINTS + 200;

  // Predicts LFO samples from its own copy of table, phases and registers,
  // and holds the samples still owed by the block.
  class lfo_scoreboard;
    int          shape[POINTS];
    bit [31:0]   phase[VOICES];
    bit          interp;
    int          level;
    int          offs;
    int          owed_sample[$];
    int          owed_voice[$];
    int          errors;
    int          n_checked;

    function new();
      foreach (phase[v]) phase[v] = '0;
      interp = 1'b1;
      level = dwlfo_pkg::Q15_MAX;
      offs = 0;
      errors = 0;
      n_checked = 0;
      restore_sine();
    endfunction

    function longint round_div(longint num, longint den);
      longint m;
      longint q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function int clamp_q15(longint x);
      if (x > dwlfo_pkg::Q15_MAX) return dwlfo_pkg::Q15_MAX;
      if (x < -dwlfo_pkg::Q15_MAX) return -dwlfo_pkg::Q15_MAX;
      return int'(x);
    endfunction

    function int sine_at(bit [31:0] p);
      bit [1:0] quad;
      longint unsigned r, x, x2, t, s, y;
      quad = p[31:30];
      r = p[29:0];
      if (quad[0]) r = dwlfo_pkg::Q30_ONE - r;
      x = (r * dwlfo_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = dwlfo_pkg::Q30_ONE - x2 / 72;
      t = dwlfo_pkg::Q30_ONE - ((x2 * t) >> 30) / 42;
      t = dwlfo_pkg::Q30_ONE - ((x2 * t) >> 30) / 20;
      t = dwlfo_pkg::Q30_ONE - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      y = (s * 32767 + (64'd1 << 29)) >> 30;
      if (y > 32767) y = 32767;
      return quad[1] ? -int'(y) : int'(y);
    endfunction

    function void restore_sine();
      for (int i = 0; i < POINTS; i++) shape[i] = sine_at(32'(i) << 22);
    endfunction

    function void smooth_shape();
      int prev[POINTS];
      longint sum;
      prev = shape;
      for (int i = 0; i < POINTS; i++) begin
        sum = 0;
        for (int k = 0; k < 5; k++) sum += prev[(i + POINTS - 2 + k) % POINTS];
        shape[i] = clamp_q15(round_div(sum, 5));
      end
    endfunction

    function void draw_line(int fi, int fv, int ti, int tv);
      int dir;
      int span;
      fv = clamp_q15(fv);
      tv = clamp_q15(tv);
      if (fi == ti) begin
        shape[ti] = tv;
        return;
      end
      dir = (ti > fi) ? 1 : -1;
      span = (ti > fi) ? ti - fi : fi - ti;
      for (int i = 0; i <= span; i++)
        shape[fi + i * dir] = clamp_q15(fv + round_div(longint'(tv - fv) * i, span));
    endfunction

    function void set_reg(dwlfo_pkg::cfg_index_t idx, bit [15:0] data);
      case (idx)
        dwlfo_pkg::CFG_INTERPOLATE: interp = data[0];
        dwlfo_pkg::CFG_LEVEL:       level = int'(data[14:0]);
        dwlfo_pkg::CFG_OFFSET:      offs = int'($signed(data));
        default: ;
      endcase
    endfunction

    // Note one accepted item: apply edits, or queue the sample a tick owes.
    function void note_item(dwlfo_pkg::cmd_t c, bit [3:0] v, bit [31:0] step, bit [9:0] fi,
                            bit signed [15:0] fv, bit [9:0] ti, bit signed [15:0] tv);
      bit [31:0] ph;
      int i0;
      longint val, d, u, g;
      case (c)
        dwlfo_pkg::CMD_DRAW:   draw_line(int'(fi), int'(fv), int'(ti), int'(tv));
        dwlfo_pkg::CMD_SMOOTH: smooth_shape();
        dwlfo_pkg::CMD_SINE:   restore_sine();
        default: begin
          ph = phase[v] + step;
          phase[v] = ph;
          i0 = int'(ph[31:22]);
          val = shape[i0];
          if (interp) begin
            d = longint'(shape[(i0 + 1) % POINTS]) - val;
            u = d * longint'({ph[21:0], 10'd0}) + (64'sd1 <<< 31) + (64'sd1 <<< 50);
            val += (u >>> 32) - (64'sd1 <<< 18);
          end
          g = round_div(val * level, 32767);
          owed_sample.push_back(clamp_q15(g + offs));
          owed_voice.push_back(int'(v));
        end
      endcase
    endfunction

    function void check_result(bit signed [15:0] sample, bit [3:0] v);
      int es, ev;
      n_checked++;
      if (owed_sample.size() == 0) begin
        $error("unexpected sample %0d for voice %0d", sample, v);
        errors++;
        return;
      end
      es = owed_sample.pop_front();
      ev = owed_voice.pop_front();
      if (int'(sample) != es) begin
        $error("sample_value: expected %0d, got %0d", es, sample);
        errors++;
      end
      if (int'(v) != ev) begin
        $error("voice_out: expected %0d, got %0d", ev, v);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = dwlfo_pkg::CMD_TICK;
  logic [3:0]         voice = '0;
  logic [31:0]        phase_step = '0;
  logic [9:0]         from_index = '0;
  logic signed [15:0] from_value = '0;
  logic [9:0]         to_index = '0;
  logic signed [15:0] to_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample_value;
  logic [3:0]         voice_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = dwlfo_pkg::CFG_INTERPOLATE;
  logic [15:0]        cfg_data = '0;

  lfo_scoreboard sb = new();
  bit long_hold_done = 1'b0;

  always #6 clk = ~clk;

  drawable_wavetable_lfo_top i_dut (
    .clk, .rst,
    .in_valid, .in_stall, .cmd, .voice, .phase_step,
    .from_index, .from_value, .to_index, .to_value,
    .out_valid, .out_stall, .sample_value, .voice_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until accepted, then hand it to the predictor.
  task automatic send_item(dwlfo_pkg::cmd_t c, bit [3:0] v, bit [31:0] step, bit [9:0] fi,
                           bit signed [15:0] fv, bit [9:0] ti, bit signed [15:0] tv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    voice <= v;
    phase_step <= step;
    from_index <= fi;
    from_value <= fv;
    to_index <= ti;
    to_value <= tv;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(c, v, step, fi, fv, ti, tv);
  endtask

  task automatic tick(bit [3:0] v, bit [31:0] step);
    send_item(dwlfo_pkg::CMD_TICK, v, step, 10'($urandom), 16'($urandom),
              10'($urandom), 16'($urandom));
  endtask

  // Stop offering and wait until every owed sample is back, then let edits finish.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.owed_sample.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(dwlfo_pkg::cfg_index_t idx, bit [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic bit [31:0] rand_step();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1 << 20);
      1: return '1 - $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    int r;
    bit [9:0] fi, ti;
    r = $urandom_range(0, 99);
    if (r < 92) begin
      tick(4'($urandom), rand_step());
    end else if (r < 97) begin
      fi = 10'($urandom);
      // keep most segments short so edits stay cheap
      ti = ($urandom_range(0, 3) == 0) ? 10'($urandom) : fi + 10'($urandom_range(0, 40)) - 10'd20;
      send_item(dwlfo_pkg::CMD_DRAW, 4'($urandom), $urandom, fi, 16'($urandom),
                ti, 16'($urandom));
    end else if (r < 99) begin
      send_item(dwlfo_pkg::CMD_SMOOTH, 4'($urandom), $urandom, 10'($urandom), 16'($urandom),
                10'($urandom), 16'($urandom));
    end else begin
      send_item(dwlfo_pkg::CMD_SINE, 4'($urandom), $urandom, 10'($urandom), 16'($urandom),
                10'($urandom), 16'($urandom));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int left;
    bit hold;
    left = 0;
    hold = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(sample_value, voice_out);
      if (!long_hold_done && sb.n_checked >= 150) begin
        long_hold_done = 1'b1;
        hold = 1'b1;
        left = 600;
      end else if (left == 0) begin
        hold = ($urandom_range(0, 2) == 0);
        left = hold ? pick_gap() : $urandom_range(1, 30);
      end else begin
        left--;
      end
      out_stall <= hold && (left > 0);
    end
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: phase extremes, every command, clamped values, equal and reversed indices.
    tick(4'd0, 32'd0);
    tick(4'd15, 32'hFFFF_FFFF);
    tick(4'd15, 32'h0000_0001);
    tick(4'd3, 32'h0040_0000);
    tick(4'd3, 32'h0020_0000);
    send_item(dwlfo_pkg::CMD_DRAW, 4'd0, 32'd0, 10'd100, -16'sd32768, 10'd100, -16'sd32768);
    send_item(dwlfo_pkg::CMD_DRAW, 4'd0, 32'd0, 10'd0, 16'sd32767, 10'd1023, -16'sd32768);
    tick(4'd5, 32'h8000_0000);
    send_item(dwlfo_pkg::CMD_DRAW, 4'd9, '1, 10'd1023, -16'sd32767, 10'd0, 16'sd32767);
    tick(4'd7, 32'hFFC0_0000);
    send_item(dwlfo_pkg::CMD_DRAW, 4'd2, 32'd7, 10'd20, 16'sd5, 10'd13, -16'sd3);
    send_item(dwlfo_pkg::CMD_SMOOTH, 4'd0, 32'd0, '0, '0, '0, '0);
    tick(4'd7, 32'h0000_0000);
    tick(4'd8, 32'h1234_5678);
    send_item(dwlfo_pkg::CMD_SINE, 4'hF, '1, '1, -16'sd1, '1, -16'sd1);
    tick(4'd0, 32'h0030_0000);
    tick(4'd1, 32'hDEAD_BEEF);
    drain(EDIT_SETTLE);

    // Register settings per phase: extremes first, then random ones.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(dwlfo_pkg::CFG_INTERPOLATE, 16'd0);
          write_reg(dwlfo_pkg::CFG_LEVEL, 16'd32767);
          write_reg(dwlfo_pkg::CFG_OFFSET, 16'h8000);
        end
        1: begin
          write_reg(dwlfo_pkg::CFG_INTERPOLATE, 16'd1);
          write_reg(dwlfo_pkg::CFG_LEVEL, 16'd0);
          write_reg(dwlfo_pkg::CFG_OFFSET, 16'd32767);
        end
        2: begin
          write_reg(dwlfo_pkg::CFG_LEVEL, 16'd32767);
          write_reg(dwlfo_pkg::CFG_OFFSET, -16'sd32767);
        end
        default: begin
          write_reg(dwlfo_pkg::CFG_INTERPOLATE, 16'($urandom));
          write_reg(dwlfo_pkg::CFG_LEVEL, 16'($urandom));
          write_reg(dwlfo_pkg::CFG_OFFSET, 16'($urandom_range(0, 2) == 0 ? $urandom : 0));
        end
      endcase
      for (int n = 0; n < 320; n++) begin
        random_item();
        // pause the sender once until every owed sample is back
        if (ph == 2 && n == 100) drain(0);
      end
      drain(EDIT_SETTLE);
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.owed_sample.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dwlfo_pkg.sv
hdl/dwlfo_div.sv
hdl/drawable_wavetable_lfo_top.sv
bench/tb_top.sv
